>>> hdl/bmde_pkg.sv
// bmde_pkg: shared types and constants for the binary mask dilate/erode core
// used by the column cells, the result queue, the top level and its checker
`default_nettype none

package bmde_pkg;

	localparam int unsigned ROW_W       = 64;
	localparam int unsigned MAX_WIDTH_D = 64;
	localparam int unsigned RW_W        = 7;
	localparam int unsigned CFG_IDX_W   = 1;
	localparam int unsigned CFG_DATA_W  = 7;
	localparam int unsigned OQ_DEPTH    = 4;
	localparam int unsigned OQ_PTR_W    = 2;
	localparam int unsigned OQ_CNT_W    = 3;
	localparam logic [RW_W-1:0] RW_RESET = RW_W'(64);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE      = 1'b0,
		REG_ROW_WIDTH = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		MODE_DILATE = 1'b0,
		MODE_ERODE  = 1'b1
	} morph_mode_t;

	typedef struct packed {
		logic              accept;
		logic              have_held;
		logic              last;
		morph_mode_t       mode;
		logic [RW_W-1:0]   row_width;
	} cell_ctl_t;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic             last;
	} res_t;

endpackage

`default_nettype wire

>>> hdl/bmde_cell.sv
// bmde_cell: one pixel column, holds the current and the upper row bit
// depends on bmde_pkg; neighbors exchange their masked bits every cycle
`default_nettype none

module bmde_cell #(
	parameter int unsigned COL = 0
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire bmde_pkg::cell_ctl_t ctl,
	input  wire logic              row_bit,
	input  wire logic              held_l,
	input  wire logic              held_r,
	input  wire logic              row_l,
	input  wire logic              row_r,
	output logic                   held_m,
	output logic                   row_m,
	output logic                   res0,
	output logic                   res1
);
	import bmde_pkg::*;

	localparam logic [RW_W-1:0] COL_V = RW_W'(COL);

	logic held_q;
	logic above_q;
	logic en;
	logic up0;
	logic up1;

	always_comb begin
		en     = ctl.row_width > COL_V;
		held_m = held_q & en;
		row_m  = row_bit & en;
		up0    = above_q & en;
		up1    = ctl.have_held & held_m;
		if (ctl.mode == MODE_ERODE) begin
			res0 = held_m & up0 & row_m & held_l & held_r;
			res1 = 1'b0;
		end else begin
			res0 = (held_m | up0 | row_m | held_l | held_r) & en;
			res1 = (row_m | up1 | row_l | row_r) & en;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q  <= 1'b0;
			above_q <= 1'b0;
		end else if (ctl.accept) begin
			if (ctl.last) begin
				held_q  <= 1'b0;
				above_q <= 1'b0;
			end else begin
				held_q  <= row_m;
				above_q <= ctl.have_held & held_q;
			end
		end
	end

endmodule

`default_nettype wire

>>> hdl/bmde_outq.sv
// bmde_outq: small result queue, takes up to two result beats per cycle
// depends on bmde_pkg for the result type and queue sizes
`default_nettype none

module bmde_outq (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push0,
	input  wire logic          push1,
	input  wire bmde_pkg::res_t d0,
	input  wire bmde_pkg::res_t d1,
	output logic               room2,
	input  wire logic          pop_ready,
	output logic               q_valid,
	output bmde_pkg::res_t     q
);
	import bmde_pkg::*;

	res_t                mem_q [OQ_DEPTH];
	logic [OQ_PTR_W-1:0] wr_ptr_q;
	logic [OQ_PTR_W-1:0] rd_ptr_q;
	logic [OQ_CNT_W-1:0] cnt_q;
	logic                pop;
	logic [OQ_CNT_W-1:0] n_push;
	res_t                first_d;

	always_comb begin
		q_valid = cnt_q != '0;
		q       = mem_q[rd_ptr_q];
		pop     = q_valid & pop_ready;
		room2   = cnt_q <= OQ_CNT_W'(OQ_DEPTH - 2);
		n_push  = OQ_CNT_W'(push0) + OQ_CNT_W'(push1);
		first_d = push0 ? d0 : d1;
	end

	always_ff @(posedge clk) begin
		if (push0 | push1) begin
			mem_q[wr_ptr_q] <= first_d;
		end
		if (push0 & push1) begin
			mem_q[wr_ptr_q + OQ_PTR_W'(1)] <= d1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + OQ_PTR_W'(n_push);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + OQ_PTR_W'(1);
			end
			cnt_q <= cnt_q + n_push - OQ_CNT_W'(pop);
		end
	end

endmodule

`default_nettype wire

>>> hdl/binary_mask_dilate_erode_core.sv
// binary_mask_dilate_erode_core: 4-neighbor dilate/erode over a row stream
// depends on bmde_pkg, bmde_cell (one per column) and bmde_outq
//
// channel  direction  handshake            payload
// row      in         row_valid/row_ready  row_bits, last_row
// res      out        res_valid/res_ready  result_row, last_out
// cfg      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one row beat per cycle while row_ready is high; its results enter the queue at the same edge and
// show on res in the cycle after at the earliest
// a row gives zero, one or two result beats, all from the column cells
// row_ready drops only when the four-entry result queue has fewer than two
// free slots; cfg_ready is always high
// reset clears the cells and the queue pointers and sets the config registers to dilate mode, row width 64
`default_nettype none

module binary_mask_dilate_erode_core #(
	parameter int unsigned MAX_WIDTH = bmde_pkg::MAX_WIDTH_D
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           row_valid,
	output logic                                row_ready,
	input  wire logic [bmde_pkg::ROW_W-1:0]     row_bits,
	input  wire logic                           last_row,
	output logic                                res_valid,
	input  wire logic                           res_ready,
	output logic [bmde_pkg::ROW_W-1:0]          result_row,
	output logic                                last_out,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [bmde_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [bmde_pkg::CFG_DATA_W-1:0] cfg_data
);
	import bmde_pkg::*;

	morph_mode_t       mode_q;
	logic [RW_W-1:0]   row_width_q;
	logic              have_held_q;
	logic              accept;
	cell_ctl_t         ctl;
	logic [MAX_WIDTH-1:0] held_v;
	logic [MAX_WIDTH-1:0] rowm_v;
	logic [MAX_WIDTH-1:0] res0_v;
	logic [MAX_WIDTH-1:0] res1_v;
	logic [MAX_WIDTH+1:0] held_pad;
	logic [MAX_WIDTH+1:0] row_pad;
	res_t              d0;
	res_t              d1;
	res_t              q;
	logic              room2;

	assign cfg_ready = 1'b1;
	assign row_ready = room2;
	assign accept    = row_valid & row_ready;

	always_comb begin
		ctl.accept    = accept;
		ctl.have_held = have_held_q;
		ctl.last      = last_row;
		ctl.mode      = mode_q;
		ctl.row_width = row_width_q;
		held_pad      = {1'b0, held_v, 1'b0};
		row_pad       = {1'b0, rowm_v, 1'b0};
		d0.row        = ROW_W'(res0_v);
		d0.last       = 1'b0;
		d1.row        = ROW_W'(res1_v);
		d1.last       = 1'b1;
		result_row    = q.row;
		last_out      = q.last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_DILATE;
			row_width_q <= RW_RESET;
		end else if (cfg_valid & cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_MODE:      mode_q      <= morph_mode_t'(cfg_data[0]);
				REG_ROW_WIDTH: row_width_q <= cfg_data[RW_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_held_q <= 1'b0;
		end else if (accept) begin
			have_held_q <= !last_row;
		end
	end

	for (genvar i = 0; i < MAX_WIDTH; i++) begin : g_col
		bmde_cell #(
			.COL(i)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.row_bit(row_bits[i]),
			.held_l (held_pad[i]),
			.held_r (held_pad[i+2]),
			.row_l  (row_pad[i]),
			.row_r  (row_pad[i+2]),
			.held_m (held_v[i]),
			.row_m  (rowm_v[i]),
			.res0   (res0_v[i]),
			.res1   (res1_v[i])
		);
	end

	bmde_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push0    (accept & have_held_q),
		.push1    (accept & last_row),
		.d0       (d0),
		.d1       (d1),
		.room2    (room2),
		.pop_ready(res_ready),
		.q_valid  (res_valid),
		.q        (q)
	);

endmodule

`default_nettype wire

>>> hdl/bmde_chk.sv
// bmde_chk: port-level checks for binary_mask_dilate_erode_core
// depends on bmde_pkg; bound to the top level at the end of this file
`default_nettype none

module bmde_chk (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       row_valid,
	input wire logic                       row_ready,
	input wire logic                       last_row,
	input wire logic                       res_valid,
	input wire logic                       res_ready,
	input wire logic [bmde_pkg::ROW_W-1:0] result_row,
	input wire logic                       last_out
);
	import bmde_pkg::*;

	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !res_valid)
		else $error("result beat shown during reset");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(result_row) && $stable(last_out))
		else $error("stalled result beat changed");

	a_last_flush: assert property (@(posedge clk) disable iff (!arst_n)
		row_valid && row_ready && last_row |=> res_valid)
		else $error("last row gave no result beat");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> row_ready)
		else $error("row not taken while no result is pending");

endmodule

bind binary_mask_dilate_erode_core bmde_chk u_bmde_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.row_valid (row_valid),
	.row_ready (row_ready),
	.last_row  (last_row),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.result_row(result_row),
	.last_out  (last_out)
);

`default_nettype wire
